// ===== hw/rtl/akb_pkg.sv =====
// akb_pkg: shared types, register indexes and pixel format helpers for the
// alpha keyed framebuffer blit; no dependencies

package akb_pkg;

  // fixed widths of the item fields and register port
  localparam int unsigned FbAddrW   = 26;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned ByteCntW  = 3;

  // alpha run threshold
  localparam logic [ColorW-1:0] KeyLevel = 8'h80;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PICTURE_WIDTH  = 3'd0,
    REG_PICTURE_HEIGHT = 3'd1,
    REG_SCREEN_STRIDE  = 3'd2,
    REG_SCREEN_ROWS    = 3'd3,
    REG_PAN_POSITION   = 3'd4,
    REG_DEST_OFFSET    = 3'd5,
    REG_PIXEL_MODE     = 3'd6,
    REG_ALPHA_ENABLE   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PM_RGB332  = 2'd0,
    PM_RGB555  = 2'd1,
    PM_RGB565  = 2'd2,
    PM_XRGB888 = 2'd3
  } pixel_mode_e;

  // per item decision from the scan counters
  typedef struct packed {
    logic write;
    logic last;
  } scan_flags_t;

  // color conversion into the framebuffer format, right aligned
  function automatic logic [PixelW-1:0] convert_pixel(
    input logic [ColorW-1:0] r,
    input logic [ColorW-1:0] g,
    input logic [ColorW-1:0] b,
    input pixel_mode_e       mode
  );
    logic [PixelW-1:0] px;
    case (mode)
      PM_RGB332:  px = {24'd0, r[7:5], g[7:5], b[7:6]};
      PM_RGB555:  px = {17'd0, r[7:3], g[7:3], b[7:3]};
      PM_RGB565:  px = {16'd0, r[7:3], g[7:2], b[7:3]};
      PM_XRGB888: px = {8'd0, r, g, b};
      default:    px = '0;
    endcase
    return px;
  endfunction

  // log2 of bytes per pixel
  function automatic logic [1:0] byte_shift(input pixel_mode_e mode);
    logic [1:0] sh;
    case (mode)
      PM_RGB332:  sh = 2'd0;
      PM_XRGB888: sh = 2'd2;
      default:    sh = 2'd1;
    endcase
    return sh;
  endfunction

  function automatic logic [ByteCntW-1:0] bytes_of(input logic [1:0] sh);
    logic [ByteCntW-1:0] n;
    case (sh)
      2'd0:    n = 3'd1;
      2'd1:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/akb_scan.sv =====
// akb_scan: raster column/row counters, window test and alpha run tracking
// depends on akb_pkg

module akb_scan import akb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [ColorW-1:0]      alpha_i,
  input  logic [15:0]            picture_width_i,
  input  logic [15:0]            picture_height_i,
  input  logic [15:0]            screen_stride_i,
  input  logic [15:0]            screen_rows_i,
  input  logic [31:0]            pan_position_i,
  input  logic                   alpha_enable_i,
  output logic [COORD_WIDTH-1:0] wx_o,
  output logic [COORD_WIDTH-1:0] wy_o,
  output scan_flags_t            flags_o
);

  localparam int unsigned SpanW = COORD_WIDTH + 1;

  logic [COORD_WIDTH-1:0] col_q, col_d, row_q, row_d;
  logic                   run_q, run_d;

  logic [COORD_WIDTH-1:0] pw_c, ph_c, st_c, sr_c, xp, yp, dx, dy;
  logic [SpanW-1:0]       pw_s, ph_s, st_s, sr_s, xc, yc;
  logic                   last_col, last, in_win, run_cur, run_new, write;

  // sizes, zero meaning the full coordinate range
  assign pw_c = picture_width_i[COORD_WIDTH-1:0];
  assign ph_c = picture_height_i[COORD_WIDTH-1:0];
  assign st_c = screen_stride_i[COORD_WIDTH-1:0];
  assign sr_c = screen_rows_i[COORD_WIDTH-1:0];
  assign pw_s = {pw_c == '0, pw_c};
  assign ph_s = {ph_c == '0, ph_c};
  assign st_s = {st_c == '0, st_c};
  assign sr_s = {sr_c == '0, sr_c};
  assign xc   = (pw_s < st_s) ? pw_s : st_s;
  assign yc   = (ph_s < sr_s) ? ph_s : sr_s;

  assign xp = pan_position_i[COORD_WIDTH-1:0];
  assign yp = pan_position_i[16 +: COORD_WIDTH];

  // window position of the current pixel
  assign dx = col_q - xp;
  assign dy = row_q - yp;
  assign in_win = (col_q >= xp) && (row_q >= yp) &&
                  ({1'b0, dx} < xc) && ({1'b0, dy} < yc);

  assign last_col = (col_q == pw_c - 1'b1);
  assign last     = last_col && (row_q == ph_c - 1'b1);

  // alpha run: restarts at each window row
  always_comb begin
    run_cur = (dx == '0) ? 1'b0 : run_q;
    if (run_cur) begin
      run_new = (alpha_i >= KeyLevel);
    end else begin
      run_new = (alpha_i > KeyLevel);
    end
    run_d = run_q;
    write = 1'b0;
    if (in_win) begin
      if (alpha_enable_i) begin
        run_d = run_new;
        write = run_new;
      end else begin
        run_d = run_cur;
        write = 1'b1;
      end
    end
  end

  // raster counters
  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last ? '0 : row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      run_q <= 1'b0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
      run_q <= run_d;
    end
  end

  assign wx_o          = dx;
  assign wy_o          = dy;
  assign flags_o.write = write;
  assign flags_o.last  = last;

endmodule

// ===== hw/rtl/alpha_keyed_framebuffer_blit.sv =====
// alpha_keyed_framebuffer_blit: windowed blit of an RGB888 + alpha pixel stream
// into framebuffer writes with format conversion; depends on akb_pkg, akb_scan
// path: a written item passes the input register, stage 1, stage 2 and the output register
// throughput: one item per cycle; the pipeline holds while the output stalls
// stages: input register, scan and convert, row multiply, address add
// reset: counters and run state cleared, registers to their defaults, no items

module alpha_keyed_framebuffer_blit import akb_pkg::*; #(
  parameter int unsigned ADDR_WIDTH  = 26,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ColorW-1:0]    red_i,
  input  logic [ColorW-1:0]    green_i,
  input  logic [ColorW-1:0]    blue_i,
  input  logic [ColorW-1:0]    alpha_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FbAddrW-1:0]   fb_address_o,
  output logic [PixelW-1:0]    pixel_value_o,
  output logic [ByteCntW-1:0]  byte_count_o,
  output logic                 frame_end_o
);

  localparam int unsigned SpanW = COORD_WIDTH + 1;
  localparam int unsigned ProdW = 2 * COORD_WIDTH + 2;
  localparam int unsigned SumW  = 2 * COORD_WIDTH + 3;
  localparam int unsigned ExtW  = (SumW + 2 > ADDR_WIDTH) ? SumW + 2 : ADDR_WIDTH;

  // configuration registers
  logic [15:0]  pic_w_q, pic_h_q, stride_q, rows_q;
  logic [31:0]  pan_q, dest_q;
  pixel_mode_e  mode_q;
  logic         alpha_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pic_w_q    <= 16'd640;
      pic_h_q    <= 16'd480;
      stride_q   <= 16'd640;
      rows_q     <= 16'd480;
      pan_q      <= '0;
      dest_q     <= '0;
      mode_q     <= PM_RGB565;
      alpha_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PICTURE_WIDTH:  pic_w_q    <= cfg_data_i[15:0];
        REG_PICTURE_HEIGHT: pic_h_q    <= cfg_data_i[15:0];
        REG_SCREEN_STRIDE:  stride_q   <= cfg_data_i[15:0];
        REG_SCREEN_ROWS:    rows_q     <= cfg_data_i[15:0];
        REG_PAN_POSITION:   pan_q      <= cfg_data_i;
        REG_DEST_OFFSET:    dest_q     <= cfg_data_i;
        REG_PIXEL_MODE:     mode_q     <= pixel_mode_e'(cfg_data_i[1:0]);
        REG_ALPHA_ENABLE:   alpha_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic out_adv, s2_free, s1_adv, s1_free, s0_adv, s0_free, in_acc;

  assign out_adv = s2_valid_q && (!out_valid_q || out_ready_i);
  assign s2_free = !s2_valid_q || out_adv;
  assign s1_adv  = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s1_adv;
  assign s0_adv  = s0_valid_q && s1_free;
  assign s0_free = !s0_valid_q || s0_adv;
  assign in_acc  = in_valid_i && s0_free;

  assign in_ready_o = s0_free;

  // input register
  logic [ColorW-1:0] r_q, g_q, b_q, a_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r_q <= red_i;
      g_q <= green_i;
      b_q <= blue_i;
      a_q <= alpha_i;
    end
  end

  // scan counters and window decision, advanced as an item leaves the input register
  logic [COORD_WIDTH-1:0] wx, wy;
  scan_flags_t            flags;

  akb_scan #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s0_adv),
    .alpha_i          (a_q),
    .picture_width_i  (pic_w_q),
    .picture_height_i (pic_h_q),
    .screen_stride_i  (stride_q),
    .screen_rows_i    (rows_q),
    .pan_position_i   (pan_q),
    .alpha_enable_i   (alpha_en_q),
    .wx_o             (wx),
    .wy_o             (wy),
    .flags_o          (flags)
  );

  // stage 1: window coordinates and converted pixel
  logic [COORD_WIDTH-1:0] s1_wx_q, s1_wy_q;
  logic [PixelW-1:0]      s1_px_q;
  logic [1:0]             s1_sh_q;
  logic                   s1_last_q;

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s1_wx_q   <= wx;
      s1_wy_q   <= wy;
      s1_px_q   <= convert_pixel(r_q, g_q, b_q, mode_q);
      s1_sh_q   <= byte_shift(mode_q);
      s1_last_q <= flags.last;
    end
  end

  // stage 2: offset row times stride, offset column
  logic [COORD_WIDTH-1:0] st_c, xo, yo;
  logic [SpanW-1:0]       st_s, ysum, xsum_d;
  logic [ProdW-1:0]       prod_d;

  assign st_c   = stride_q[COORD_WIDTH-1:0];
  assign st_s   = {st_c == '0, st_c};
  assign xo     = dest_q[COORD_WIDTH-1:0];
  assign yo     = dest_q[16 +: COORD_WIDTH];
  assign ysum   = SpanW'(yo) + SpanW'(s1_wy_q);
  assign xsum_d = SpanW'(xo) + SpanW'(s1_wx_q);
  assign prod_d = ProdW'(ysum) * ProdW'(st_s);

  logic [ProdW-1:0]  s2_prod_q;
  logic [SpanW-1:0]  s2_xsum_q;
  logic [PixelW-1:0] s2_px_q;
  logic [1:0]        s2_sh_q;
  logic              s2_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_prod_q <= prod_d;
      s2_xsum_q <= xsum_d;
      s2_px_q   <= s1_px_q;
      s2_sh_q   <= s1_sh_q;
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: add column, scale to bytes, wrap the address
  logic [SumW-1:0]       sum;
  logic [ExtW-1:0]       addr_ext;
  logic [ADDR_WIDTH-1:0] addr_wrap;

  assign sum       = SumW'(s2_prod_q) + SumW'(s2_xsum_q);
  assign addr_ext  = ExtW'(sum) << s2_sh_q;
  assign addr_wrap = addr_ext[ADDR_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      fb_address_o  <= FbAddrW'(addr_wrap);
      pixel_value_o <= s2_px_q;
      byte_count_o  <= bytes_of(s2_sh_q);
      frame_end_o   <= s2_last_q;
    end
  end

  // valid bits; items that are not written drop out at stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s0_valid_q <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_q <= 1'b0;
      end
      if (s0_adv) begin
        s1_valid_q <= flags.write;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (out_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
